FILE: rtl/qsu_pkg.sv
// Package for the quoted string unescaper: character codes, status codes,
// the phase type and the result item type. No dependencies.
`default_nettype none

package qsu_pkg;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [CSR_ADDR_WIDTH-3:0] CSR_REJECT_TRAILING = '0;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_EQUALS    = 8'h3D;
   localparam logic [7:0] CH_SEMICOLON = 8'h3B;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_VT        = 8'h0B;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_BS        = 8'h08;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_OPEN    = 3'd1;
   localparam logic [2:0] ST_NO_CLOSE   = 3'd2;
   localparam logic [2:0] ST_SPECIAL    = 3'd3;
   localparam logic [2:0] ST_ILLEGAL    = 3'd4;
   localparam logic [2:0] ST_TRAILING   = 3'd5;

   typedef enum logic [2:0] {
      PH_LEAD  = 3'd0,
      PH_BODY  = 3'd1,
      PH_ESC   = 3'd2,
      PH_HEX0  = 3'd3,
      PH_HEX1  = 3'd4,
      PH_AFTER = 3'd5,
      PH_DONE  = 3'd6
   } phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [2:0] status;
      logic       has_trailing;
      logic       last;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

   // Returns {valid, nibble} for one hex digit of either case.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/quoted_string_unescape.sv
// Top level of the quoted string unescaper: byte parser, result queue and
// register port. Depends on qsu_pkg.
`default_nettype none

// Quoted string unescaper. Each request carries one byte of a text. The
// block skips leading whitespace, checks for an opening double quote and
// returns the unescaped content bytes as data results (kind 0). Escapes
// \b \f \n \r \t \" \\ are decoded, \x takes up to two hex digits, and a
// backslash before a newline is dropped along with it. The request marked
// end_of_text also yields a status result (kind 1, last 1). After an error
// status, the data already returned for that text is void. The parser state
// is updated in the same cycle the request is accepted. The up to three
// results a request can cause go into a four-entry result queue, which
// drains one result per cycle while the output is not stalled. A result is
// offered on the output once the results queued before it have drained.
// Requests stall while more than one result is waiting, that is while the
// queue has fewer than three free entries. With the output not stalled, a
// request is taken every cycle as long as each request causes at most one
// result. A request that causes two or three results holds off the next one
// while the queue drains. The single register reject_trailing (byte address
// 0, reset 1) turns text after the closing quote into an error; when it is
// clear, such text is only flagged in has_trailing.
module quoted_string_unescape (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [7:0]                          req_text_byte,
   input  wire                                 req_end_of_text,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic                                rsp_kind,
   output logic [7:0]                          rsp_data_byte,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_has_trailing,
   output logic                                rsp_last,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [qsu_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire  [qsu_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [qsu_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import qsu_pkg::*;

   // Parser state, updated only when a request is accepted, and the register bit.
   phase_type  phase_ff, phase_in;
   logic [3:0] hex_nibble_ff, hex_nibble_in;
   logic [2:0] error_code_ff, error_code_in;
   logic       trailing_ff, trailing_in;
   logic       reject_trailing_ff;

   // Result queue.
   result_type                fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_WIDTH-1:0] count_ff;

   // Results produced by the request at the input this cycle.
   result_type res_c [MAX_RESULTS];
   logic [1:0] nres_c;

   logic req_accept;
   logic rsp_accept;
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_WIDTH-1:2] == CSR_REJECT_TRAILING) begin
         csr_prdata[0] = reject_trailing_ff;
      end
   end

   // The queue must be able to take a full burst of results, so a request
   // waits while fewer than MAX_RESULTS entries are free.
   assign req_stall  = (count_ff > FIFO_CNT_WIDTH'(FIFO_DEPTH - MAX_RESULTS));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;

   // Byte parser. The body-byte handling is shared by the content phase
   // and by a hex escape that ends on a non-hex byte, which first returns
   // the pending value and then treats the byte as ordinary content.
   always_comb begin
      logic [7:0] c;
      logic [4:0] hx;
      logic       body_go;
      logic [2:0] st;

      c             = req_text_byte;
      hx            = hex_digit(c);
      body_go       = 1'b0;
      st            = ST_OK;
      phase_in      = phase_ff;
      hex_nibble_in = hex_nibble_ff;
      error_code_in = error_code_ff;
      trailing_in   = trailing_ff;
      nres_c        = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_c[i] = '0;
      end

      if (phase_ff != PH_DONE && c == CH_NUL) begin
         // A zero byte ends the text; a pending hex value is dropped.
         case (phase_ff)
            PH_LEAD: begin
               error_code_in = ST_NO_OPEN;
               phase_in      = PH_DONE;
            end
            PH_AFTER: begin
               phase_in = PH_DONE;
            end
            default: begin
               error_code_in = ST_NO_CLOSE;
               phase_in      = PH_DONE;
            end
         endcase
      end else begin
         case (phase_ff)
            PH_LEAD: begin
               if (c == CH_QUOTE) begin
                  phase_in = PH_BODY;
               end else if (!is_space(c)) begin
                  error_code_in = ST_NO_OPEN;
                  phase_in      = PH_DONE;
               end
            end
            PH_BODY: begin
               body_go = 1'b1;
            end
            PH_ESC: begin
               phase_in = PH_BODY;
               case (c)
                  CH_B:         res_c[0].data_byte = CH_BS;
                  CH_F:         res_c[0].data_byte = CH_FF;
                  CH_N:         res_c[0].data_byte = CH_LF;
                  CH_R:         res_c[0].data_byte = CH_CR;
                  CH_T:         res_c[0].data_byte = CH_TAB;
                  CH_QUOTE:     res_c[0].data_byte = CH_QUOTE;
                  CH_BACKSLASH: res_c[0].data_byte = CH_BACKSLASH;
                  default:      res_c[0].data_byte = CH_NUL;
               endcase
               if (c inside {CH_B, CH_F, CH_N, CH_R, CH_T, CH_QUOTE, CH_BACKSLASH}) begin
                  nres_c = 2'd1;
               end else if (c == CH_LF) begin
                  // Line continuation: nothing is returned.
               end else if (c == CH_X) begin
                  phase_in = PH_HEX0;
               end else if (c inside {CH_EQUALS, CH_SEMICOLON, CH_COMMA}) begin
                  error_code_in = ST_SPECIAL;
                  phase_in      = PH_DONE;
               end else begin
                  error_code_in = ST_ILLEGAL;
                  phase_in      = PH_DONE;
               end
            end
            PH_HEX0: begin
               if (hx[4]) begin
                  hex_nibble_in = hx[3:0];
                  phase_in      = PH_HEX1;
               end else begin
                  nres_c  = 2'd1;
                  body_go = 1'b1;
               end
            end
            PH_HEX1: begin
               nres_c = 2'd1;
               if (hx[4]) begin
                  res_c[0].data_byte = {hex_nibble_ff, hx[3:0]};
                  phase_in           = PH_BODY;
               end else begin
                  res_c[0].data_byte = {4'd0, hex_nibble_ff};
                  body_go            = 1'b1;
               end
            end
            PH_AFTER: begin
               if (!is_space(c)) begin
                  trailing_in = 1'b1;
                  phase_in    = PH_DONE;
               end
            end
            default: begin
               // Finished: bytes are ignored until the end of the text.
            end
         endcase
      end

      if (body_go) begin
         phase_in = PH_BODY;
         if (c == CH_QUOTE) begin
            phase_in = PH_AFTER;
         end else if (c == CH_BACKSLASH) begin
            phase_in = PH_ESC;
         end else begin
            res_c[nres_c].data_byte = c;
            nres_c                  = nres_c + 2'd1;
         end
      end

      if (req_end_of_text) begin
         if (phase_in == PH_LEAD) begin
            error_code_in = ST_NO_OPEN;
         end else if (phase_in != PH_AFTER && phase_in != PH_DONE) begin
            error_code_in = ST_NO_CLOSE;
         end
         st = error_code_in;
         if (st == ST_OK && trailing_in && reject_trailing_ff) begin
            st = ST_TRAILING;
         end
         res_c[nres_c].kind         = 1'b1;
         res_c[nres_c].status       = st;
         res_c[nres_c].has_trailing = trailing_in;
         res_c[nres_c].last         = 1'b1;
         nres_c                     = nres_c + 2'd1;
         // Back to the reset state for the next text.
         phase_in      = PH_LEAD;
         hex_nibble_in = 4'd0;
         error_code_in = ST_OK;
         trailing_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_LEAD;
         hex_nibble_ff      <= 4'd0;
         error_code_ff      <= ST_OK;
         trailing_ff        <= 1'b0;
         reject_trailing_ff <= 1'b1;
      end else begin
         if (req_accept) begin
            phase_ff      <= phase_in;
            hex_nibble_ff <= hex_nibble_in;
            error_code_ff <= error_code_in;
            trailing_ff   <= trailing_in;
         end
         if (csr_write && csr_paddr[CSR_ADDR_WIDTH-1:2] == CSR_REJECT_TRAILING) begin
            reject_trailing_ff <= csr_pwdata[0];
         end
      end
   end

   // Queue storage holds payload only and needs no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < nres_c) begin
               fifo_ff[wr_ptr_ff + FIFO_PTR_WIDTH'(i)] <= res_c[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_accept) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_WIDTH'(nres_c);
         end
         if (rsp_accept) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_WIDTH'(1);
         end
         count_ff <= count_ff
                   + (req_accept ? FIFO_CNT_WIDTH'(nres_c) : FIFO_CNT_WIDTH'(0))
                   - (rsp_accept ? FIFO_CNT_WIDTH'(1) : FIFO_CNT_WIDTH'(0));
      end
   end

   assign rsp_kind         = fifo_ff[rd_ptr_ff].kind;
   assign rsp_data_byte    = fifo_ff[rd_ptr_ff].data_byte;
   assign rsp_status       = fifo_ff[rd_ptr_ff].status;
   assign rsp_has_trailing = fifo_ff[rd_ptr_ff].has_trailing;
   assign rsp_last         = fifo_ff[rd_ptr_ff].last;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the quoted string unescaper: it drives text bytes,
// writes the trailing-text register over APB and checks every result against
// a built-in predictor. Depends on qsu_pkg and quoted_string_unescape.
`default_nettype none

module tb_top;
   import qsu_pkg::*;

   // Cycles without any handshake before the run is declared hung. The
   // longest legal quiet stretch is the receiver hold-off plus a few gaps.
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   // Length of the one long receiver hold-off that backs the block up.
   localparam int unsigned HOLD_CYCLES = 60;
   // Settling time after the last result before a register write or the end.
   localparam int unsigned SETTLE_CYCLES = 8;

   // Hex digit bounds that the package does not name.
   localparam logic [7:0] CH_DIGIT0  = 8'h30;
   localparam logic [7:0] CH_DIGIT9  = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   localparam logic [CSR_ADDR_WIDTH-1:0] REJECT_TRAILING_ADDR = {CSR_REJECT_TRAILING, 2'b00};

   // One request waiting to be offered, with the idle cycles that come first.
   typedef struct {
      logic [7:0]  text_byte;
      logic        end_of_text;
      int unsigned gap;
   } text_req_type;

   // Every input of the block starts from a known value.
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_text_byte = 8'h00;
   logic                      req_end_of_text = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_kind;
   logic [7:0]                rsp_data_byte;
   logic [2:0]                rsp_status;
   logic                      rsp_has_trailing;
   logic                      rsp_last;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // Stimulus queue and the results the predictor says are still to come.
   text_req_type pending_bytes[$];
   result_type   due_results[$];
   int unsigned  queued_count = 0;
   int unsigned  mismatch_count = 0;

   // Handshake flags, sampled at the rising edge and read at the falling one.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // Idling is switched off for some phases to get back-to-back traffic.
   logic        idling_on = 1'b1;
   int unsigned hold_orders = 0;

   // Predictor state and its copy of the register.
   phase_type  scan_phase = PH_LEAD;
   logic [3:0] held_nibble = 4'h0;
   logic [2:0] first_error = ST_OK;
   logic       saw_trailing = 1'b0;
   logic       reject_trailing_cfg = 1'b1;

   quoted_string_unescape i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_status       (rsp_status),
      .rsp_has_trailing (rsp_has_trailing),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

   // Value of a hex digit of either case, or -1 for any other byte.
   function automatic int hex_value(input logic [7:0] c);
      if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return int'(c - CH_DIGIT0);
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
      return -1;
   endfunction

   function automatic void add_data(input logic [7:0] d);
      due_results.insert(due_results.size(), result_type'{1'b0, d, ST_OK, 1'b0, 1'b0});
   endfunction

   // The first error sticks; everything after it up to end of text is ignored.
   function automatic void stop_on(input logic [2:0] code);
      first_error = code;
      scan_phase = PH_DONE;
   endfunction

   // A nonzero byte inside the string: a quote, a backslash or ordinary content.
   function automatic void content_byte(input logic [7:0] c);
      scan_phase = PH_BODY;
      if (c == CH_QUOTE) begin
         scan_phase = PH_AFTER;
      end else if (c == CH_BACKSLASH) begin
         scan_phase = PH_ESC;
      end else begin
         add_data(c);
      end
   endfunction

   // Advances the predicted parser by one accepted request and queues the
   // results that request must produce, in order.
   function automatic void unescape_byte(input logic [7:0] c, input logic eot);
      int         h;
      logic [2:0] st;
      h = hex_value(c);
      if (scan_phase != PH_DONE && c == CH_NUL) begin
         // A zero byte ends the text; a pending hex value is dropped.
         if (scan_phase == PH_LEAD) begin
            stop_on(ST_NO_OPEN);
         end else if (scan_phase == PH_AFTER) begin
            scan_phase = PH_DONE;
         end else begin
            stop_on(ST_NO_CLOSE);
         end
      end else begin
         case (scan_phase)
            PH_LEAD: begin
               if (c == CH_QUOTE) begin
                  scan_phase = PH_BODY;
               end else if (!is_blank(c)) begin
                  stop_on(ST_NO_OPEN);
               end
            end
            PH_BODY: content_byte(c);
            PH_ESC: begin
               scan_phase = PH_BODY;
               case (c)
                  CH_B:                              add_data(CH_BS);
                  CH_F:                              add_data(CH_FF);
                  CH_N:                              add_data(CH_LF);
                  CH_R:                              add_data(CH_CR);
                  CH_T:                              add_data(CH_TAB);
                  CH_QUOTE, CH_BACKSLASH:            add_data(c);
                  CH_LF: begin
                     // Line continuation: both bytes vanish.
                  end
                  CH_X:                              scan_phase = PH_HEX0;
                  CH_EQUALS, CH_SEMICOLON, CH_COMMA: stop_on(ST_SPECIAL);
                  default:                           stop_on(ST_ILLEGAL);
               endcase
            end
            PH_HEX0: begin
               if (h >= 0) begin
                  held_nibble = h[3:0];
                  scan_phase = PH_HEX1;
               end else begin
                  // A hex escape without digits yields zero, and the byte
                  // that ended it is treated as ordinary content.
                  add_data(CH_NUL);
                  content_byte(c);
               end
            end
            PH_HEX1: begin
               if (h >= 0) begin
                  add_data({held_nibble, h[3:0]});
                  scan_phase = PH_BODY;
               end else begin
                  add_data({4'h0, held_nibble});
                  content_byte(c);
               end
            end
            PH_AFTER: begin
               // Only the first non-blank byte after the closing quote counts.
               if (!is_blank(c)) begin
                  saw_trailing = 1'b1;
                  scan_phase = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end

      if (eot) begin
         // End of text without a terminator behaves as if a zero followed.
         if (scan_phase == PH_LEAD) begin
            first_error = ST_NO_OPEN;
         end else if (scan_phase != PH_AFTER && scan_phase != PH_DONE) begin
            first_error = ST_NO_CLOSE;
         end
         st = first_error;
         if (st == ST_OK && saw_trailing && reject_trailing_cfg) begin
            st = ST_TRAILING;
         end
         due_results.insert(due_results.size(),
                            result_type'{1'b1, 8'h00, st, saw_trailing, 1'b1});
         scan_phase = PH_LEAD;
         held_nibble = 4'h0;
         first_error = ST_OK;
         saw_trailing = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Monitor: at every rising edge it records both handshakes, feeds an
   // accepted request to the predictor and compares an accepted result with
   // the oldest one due. It also runs the watchdog.
   always @(posedge clock) begin : monitor
      result_type  want;
      int unsigned quiet_cycles;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            unescape_byte(req_text_byte, req_end_of_text);
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            if (due_results.size() == 0) begin
               report_mismatch("result with nothing due, data_byte", rsp_data_byte, 0);
            end else begin
               want = due_results.pop_front();
               if (rsp_kind != want.kind)
                  report_mismatch("kind", rsp_kind, want.kind);
               if (rsp_data_byte != want.data_byte)
                  report_mismatch("data_byte", rsp_data_byte, want.data_byte);
               if (rsp_status != want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_has_trailing != want.has_trailing)
                  report_mismatch("has_trailing", rsp_has_trailing, want.has_trailing);
               if (rsp_last != want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
      end
      if (req_taken || rsp_taken || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------

   // At each falling edge a new request is presented once the previous one
   // was taken and the idle gap drawn for the new one has passed. A stalled
   // request is held unchanged.
   always @(negedge clock) begin : drive_requests
      text_req_type nxt;
      int unsigned  req_waited;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_bytes.size() != 0 && req_waited >= pending_bytes[0].gap) begin
            nxt = pending_bytes.pop_front();
            req_text_byte <= nxt.text_byte;
            req_end_of_text <= nxt.end_of_text;
            req_valid <= 1'b1;
            req_waited = 0;
         end else begin
            if (pending_bytes.size() != 0) req_waited++;
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result receiver
   // ------------------------------------------------------------------

   // After each accepted result, with idling on, the receiver stalls for a drawn
   // number of cycles. On request from the stimulus it also holds off for a long
   // stretch so that the result queue fills and the block stalls its input.
   always @(negedge clock) begin : drive_stall
      int unsigned hold_left;
      int unsigned hold_served;
      int unsigned rsp_wait;
      if (!reset) begin
         if (rsp_taken && idling_on) rsp_wait = $urandom_range(0, 8);
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_served != hold_orders) begin
            hold_served = hold_orders;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   task automatic send(input logic [7:0] c, input logic eot);
      text_req_type r;
      r.text_byte = c;
      r.end_of_text = eot;
      r.gap = idling_on ? $urandom_range(0, 8) : 0;
      pending_bytes.insert(pending_bytes.size(), r);
      queued_count++;
   endtask

   task automatic send_string(input string s, input logic eot_last);
      for (int i = 0; i < s.len(); i++) begin
         send(s[i], eot_last && (i == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 5))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_LF;
         3:       return CH_VT;
         4:       return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   function automatic logic [7:0] pick_simple_escape();
      case ($urandom_range(0, 6))
         0:       return CH_B;
         1:       return CH_F;
         2:       return CH_N;
         3:       return CH_R;
         4:       return CH_T;
         5:       return CH_QUOTE;
         default: return CH_BACKSLASH;
      endcase
   endfunction

   function automatic logic [7:0] pick_hex_digit();
      case ($urandom_range(0, 2))
         0:       return CH_DIGIT0 + 8'($urandom_range(0, 9));
         1:       return CH_UPPER_A + 8'($urandom_range(0, 5));
         default: return CH_LOWER_A + 8'($urandom_range(0, 5));
      endcase
   endfunction

   // Any byte that does not end, open or close the string or start an escape.
   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == CH_QUOTE || c == CH_BACKSLASH);
      return c;
   endfunction

   // Queues one random text. Most texts are well formed with random
   // content; the rest lack a quote, carry a bad escape or are pure noise.
   task automatic queue_random_text();
      logic [7:0]  t[$];
      logic [7:0]  c;
      int unsigned mode;
      mode = $urandom_range(0, 19);
      if (mode < 3) begin
         if ($urandom_range(0, 1)) t.insert(t.size(), CH_QUOTE);
         repeat ($urandom_range(1, 7)) t.insert(t.size(), 8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2)) t.insert(t.size(), pick_blank());
         // Mode 3 drops the opening quote.
         t.insert(t.size(), mode == 3 ? 8'($urandom_range(0, 255)) : CH_QUOTE);
         repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 5))
               0, 1: t.insert(t.size(), pick_plain());
               2: begin
                  t.insert(t.size(), CH_BACKSLASH);
                  t.insert(t.size(), pick_simple_escape());
               end
               3: begin
                  t.insert(t.size(), CH_BACKSLASH);
                  t.insert(t.size(), CH_LF);
               end
               4: begin
                  t.insert(t.size(), CH_BACKSLASH);
                  t.insert(t.size(), CH_X);
                  repeat ($urandom_range(0, 2)) t.insert(t.size(), pick_hex_digit());
               end
               default: begin
                  // Broken escapes only in a few texts.
                  if (mode >= 17) begin
                     t.insert(t.size(), CH_BACKSLASH);
                     case ($urandom_range(0, 3))
                        0:       t.insert(t.size(), CH_EQUALS);
                        1:       t.insert(t.size(), CH_SEMICOLON);
                        2:       t.insert(t.size(), CH_COMMA);
                        default: t.insert(t.size(), 8'($urandom_range(0, 255)));
                     endcase
                  end else begin
                     t.insert(t.size(), pick_plain());
                  end
               end
            endcase
         end
         // Mode 4 leaves the string unclosed.
         if (mode != 4) begin
            t.insert(t.size(), CH_QUOTE);
            repeat ($urandom_range(0, 2)) t.insert(t.size(), pick_blank());
            if ($urandom_range(0, 2) == 0) begin
               do c = 8'($urandom_range(1, 255));
               while (is_blank(c));
               t.insert(t.size(), c);
               repeat ($urandom_range(0, 2)) t.insert(t.size(), 8'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 1)) begin
            t.insert(t.size(), CH_NUL);
            if ($urandom_range(0, 2) == 0) begin
               repeat ($urandom_range(1, 2)) t.insert(t.size(), 8'($urandom_range(0, 255)));
            end
         end
      end
      for (int i = 0; i < t.size(); i++) begin
         send(t[i], i == t.size() - 1);
      end
   endtask

   task automatic queue_random(input int unsigned n);
      int unsigned start;
      start = queued_count;
      while (queued_count - start < n) queue_random_text();
   endtask

   // Waits until every request went out and every due result came back,
   // then lets the block settle, since a request may cause no result.
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || due_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write of the trailing-text register, followed by a read-back.
   // Upper data bits are random; only bit 0 is stored.
   task automatic write_reject_trailing(input logic value);
      logic [CSR_DATA_WIDTH-1:0] word;
      word = $urandom;
      word[0] = value;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= REJECT_TRAILING_ADDR;
      csr_pwdata <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      reject_trailing_cfg = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata != CSR_DATA_WIDTH'(value)) begin
         report_mismatch("reject_trailing read-back", csr_prdata, value);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed texts with text after the closing quote rejected.
      write_reject_trailing(1'b1);
      send(CH_QUOTE, 1'b0);               // all-ones content byte
      send(8'hFF, 1'b0);
      send(CH_QUOTE, 1'b1);
      send(CH_SPACE, 1'b0);               // zero byte before the quote
      send(CH_NUL, 1'b1);
      send_string("\"\\x4", 1'b0);        // zero byte inside a hex escape
      send(CH_NUL, 1'b1);
      send_string("\"\\=", 1'b1);         // special-character escape, no terminator
      send_string("\"\\q\"", 1'b1);       // illegal escape, later bytes ignored
      send_string("\"a\" b", 1'b1);       // trailing text rejected
      send_string("\"\\x4g\"", 1'b1);     // one hex digit, then ordinary content
      wait_idle();

      // Trailing text only flagged, then random texts with idling.
      write_reject_trailing(1'b0);
      send_string("\"a\" b", 1'b1);
      queue_random(80);
      wait_idle();

      // Back-to-back traffic with one long receiver hold-off.
      write_reject_trailing(1'b1);
      idling_on = 1'b0;
      queue_random(80);
      hold_orders++;
      wait_idle();

      idling_on = 1'b1;
      write_reject_trailing(1'b0);
      queue_random(80);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/qsu_pkg.sv
rtl/quoted_string_unescape.sv
sim/tb_top.sv
